@@ hdl/assert_macros.svh @@
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define A_IMPL(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define A_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define A_IMPL(lbl, clk, rst_n, a, c)
`define A_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

@@ hdl/egcd_pkg.sv @@
package egcd_pkg;
	localparam int OpW = 32;
	localparam int CoefW = OpW + 1;
	localparam int QDepth = 64;
	localparam int QAddrW = $clog2(QDepth);
	localparam int CntW = QAddrW + 1;
	localparam int DivCntW = $clog2(OpW + 1);

	typedef struct packed {
		logic [OpW-1:0] first_value;
		logic [OpW-1:0] second_value;
	} in_t;

	typedef struct packed {
		logic [OpW-1:0]          divisor;
		logic signed [CoefW-1:0] coef_first;
		logic signed [CoefW-1:0] coef_second;
		logic                    bad_input;
	} out_t;

	typedef struct packed {
		logic           start;
		logic [OpW-1:0] dividend;
		logic [OpW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic           done;
		logic [OpW-1:0] quot;
		logic [OpW-1:0] rem;
	} div_rsp_t;
endpackage

@@ hdl/egcd_if.sv @@
interface egcd_if #(parameter int W = 64);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ hdl/extended_gcd_bezout.sv @@
// Operation: a chain of division steps, then back-substitution of the stored quotients.
// Throughput: one item at a time; the shared bit-serial divider sets the rate.
// A result waits in its output register while the next item is accepted.
// Reset: arst_n clears all control state; the quotient RAM is not cleared.
module extended_gcd_bezout (
	input logic clk,
	input logic arst_n,
	egcd_if.sink   in_ch,
	egcd_if.source out_ch
);
	import egcd_pkg::*;
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_WAIT = 3'd2;
	localparam logic [2:0] S_BRD  = 3'd3;
	localparam logic [2:0] S_BMUL = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]       st_q;
	logic [OpW-1:0]   hi_q, lo_q;
	logic             sw_q;
	logic             bad_q;
	logic [CntW-1:0]  n_q, m_q;
	logic [CoefW-1:0] prev_q, cur_q;
	div_req_t         dreq;
	div_rsp_t         drsp;
	logic             we;
	logic [QAddrW-1:0] raddr;
	logic [OpW-1:0]   qrd;
	out_t             res_q;
	logic             res_v_q;
	in_t              inw;
	logic [CoefW-1:0] c_hi, c_lo;

	assign inw = in_t'(in_ch.data);
	assign in_ch.ready = (st_q == S_IDLE);

	egcd_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign we = (st_q == S_WAIT) && drsp.done;
	assign raddr = QAddrW'(m_q - 1'b1);
	egcd_ram #(.Width(OpW), .Depth(QDepth)) u_qram (
		.clk(clk), .we(we), .waddr(n_q[QAddrW-1:0]), .wdata(drsp.quot),
		.raddr(raddr), .rdata(qrd)
	);

	always_comb begin
		dreq.start    = (st_q == S_DIV);
		dreq.dividend = hi_q;
		dreq.divisor  = lo_q;
	end

	assign c_hi = prev_q;
	assign c_lo = cur_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			res_v_q <= 1'b0;
			n_q     <= '0;
			m_q     <= '0;
		end else begin
			if (st_q == S_DONE && (!res_v_q || out_ch.ready)) res_v_q <= 1'b1;
			else if (out_ch.ready) res_v_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						n_q <= '0;
						if (inw.first_value == '0 && inw.second_value == '0) st_q <= S_DONE;
						else if (inw.first_value == '0 || inw.second_value == '0)
							st_q <= S_DONE;
						else st_q <= S_DIV;
					end
				end
				S_DIV: st_q <= S_WAIT;
				S_WAIT: begin
					if (drsp.done) begin
						n_q <= n_q + 1'b1;
						if (drsp.rem == '0 || n_q == CntW'(QDepth - 1)) begin
							m_q  <= n_q;
							st_q <= S_BRD;
						end else st_q <= S_DIV;
					end
				end
				S_BRD: begin
					if (m_q == '0) st_q <= S_DONE;
					else st_q <= S_BMUL;
				end
				S_BMUL: begin
					m_q  <= m_q - 1'b1;
					st_q <= S_BRD;
				end
				S_DONE: begin
					if (!res_v_q || out_ch.ready) st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// Note: S_BMUL applies the product of the quotient read in S_BRD.
	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				sw_q   <= inw.first_value < inw.second_value;
				hi_q   <= (inw.first_value < inw.second_value) ?
					inw.second_value : inw.first_value;
				lo_q   <= (inw.first_value < inw.second_value) ?
					inw.first_value : inw.second_value;
				prev_q <= CoefW'(1);
				cur_q  <= '0;
				bad_q  <= (inw.first_value == '0 && inw.second_value == '0);
			end
			S_WAIT: begin
				if (drsp.done) begin
					hi_q   <= lo_q;
					lo_q   <= drsp.rem;
					prev_q <= '0;
					cur_q  <= CoefW'(1);
				end
			end
			S_BMUL: begin
				prev_q <= cur_q;
				cur_q  <= prev_q - CoefW'(cur_q * {1'b0, qrd});
			end
			S_DONE: begin
				if (!res_v_q || out_ch.ready) begin
					res_q.bad_input   <= bad_q;
					res_q.divisor     <= bad_q ? '0 : hi_q;
					res_q.coef_first  <= bad_q ? '0 : (sw_q ? c_lo : c_hi);
					res_q.coef_second <= bad_q ? '0 : (sw_q ? c_hi : c_lo);
				end
			end
			default: ;
		endcase
	end

	assign out_ch.valid = res_v_q;
	assign out_ch.data  = res_q;

	`A_IMPL(a_no_accept_busy, clk, arst_n, st_q != S_IDLE, !in_ch.ready)
	`A_IMPL(a_cnt_bound, clk, arst_n, st_q == S_WAIT, n_q < CntW'(QDepth))
	`A_NEXT(a_div_launch, clk, arst_n, st_q == S_DIV, st_q == S_WAIT)
endmodule

@@ hdl/egcd_ram.sv @@
module egcd_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ hdl/egcd_div.sv @@
`include "assert_macros.svh"
module egcd_div (
	input  logic                clk,
	input  logic                arst_n,
	input  egcd_pkg::div_req_t  req,
	output egcd_pkg::div_rsp_t  rsp
);
	import egcd_pkg::*;
	logic               busy_q;
	logic               done_q;
	logic [DivCntW-1:0] cnt_q;
	logic [OpW-1:0]     rem_q, quo_q, dsr_q;
	logic [OpW:0]       trial;
	logic [OpW:0]       shifted;

	// restoring division, one quotient bit per cycle
	assign shifted = {rem_q, quo_q[OpW-1]};
	assign trial   = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DivCntW'(OpW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DivCntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[OpW]) rem_q <= trial[OpW-1:0];
			else rem_q <= shifted[OpW-1:0];
			quo_q <= {quo_q[OpW-2:0], ~trial[OpW]};
		end
	end
	assign rsp = '{done: done_q, quot: quo_q, rem: rem_q};

	`A_NEXT(a_done_pulse, clk, arst_n, rsp.done, !rsp.done)
	`A_IMPL(a_done_busy, clk, arst_n, rsp.done, !busy_q)
	`A_NEXT(a_start_busy, clk, arst_n, req.start, busy_q)
endmodule

@@ bench/egcd_scoreboard.sv @@
`timescale 1ns / 100ps

module egcd_scoreboard
	import egcd_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	egcd_if      in_mon,
	egcd_if      out_mon,
	output int   mismatches,
	output int   outstanding
);

	out_t gcd_expected[$];

	// Euclid chain on (larger, smaller), then back-substitute the stored quotients
	function automatic out_t bezout_of(input logic [OpW-1:0] a, input logic [OpW-1:0] b);
		logic [63:0] hi, lo, r, prev, cur, nxt, c_hi, c_lo;
		logic [63:0] quot_log[QDepth];
		logic        swapped;
		int          n;
		out_t        res;
		res = '0;
		n = 0;
		swapped = (a < b);
		hi = swapped ? {32'd0, b} : {32'd0, a};
		lo = swapped ? {32'd0, a} : {32'd0, b};
		if (a == 0 && b == 0) begin
			res.bad_input = 1'b1;
			return res;
		end
		if (lo == 0) begin
			c_hi = 64'd1;
			c_lo = 64'd0;
		end else begin
			while (lo != 0 && n < QDepth) begin
				quot_log[n] = hi / lo;
				r = hi % lo;
				n++;
				hi = lo;
				lo = r;
			end
			prev = 64'd0;
			cur = 64'd1;
			for (int m = n - 1; m >= 1; m--) begin
				nxt = prev - cur * quot_log[m-1];
				prev = cur;
				cur = nxt;
			end
			c_hi = prev;
			c_lo = cur;
		end
		res.divisor = hi[OpW-1:0];
		res.coef_first = swapped ? c_lo[CoefW-1:0] : c_hi[CoefW-1:0];
		res.coef_second = swapped ? c_hi[CoefW-1:0] : c_lo[CoefW-1:0];
		res.bad_input = 1'b0;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		in_t  opnd;
		out_t got, want;
		if (!arst_n) begin
			mismatches <= 0;
			outstanding <= 0;
			gcd_expected.delete();
		end else begin
			if (in_mon.valid && in_mon.ready) begin
				opnd = in_t'(in_mon.data);
				gcd_expected.push_back(bezout_of(opnd.first_value, opnd.second_value));
			end
			if (out_mon.valid && out_mon.ready) begin
				got = out_t'(out_mon.data);
				if (gcd_expected.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result transfer: %p", got);
					mismatches <= mismatches + 1;
				end else begin
					want = gcd_expected.pop_front();
					if (got.divisor !== want.divisor || got.coef_first !== want.coef_first
							|| got.coef_second !== want.coef_second
							|| got.bad_input !== want.bad_input) begin
						if (mismatches < 10)
							$display("result mismatch: expected %p, got %p", want, got);
						mismatches <= mismatches + 1;
					end
				end
			end
			outstanding <= gcd_expected.size();
		end
	end

endmodule

@@ bench/tb_extended_gcd_bezout.sv @@
`timescale 1ns / 100ps

module tb_extended_gcd_bezout;
	import egcd_pkg::*;

	localparam int CycleLimit = 4000000;
	localparam int RandomItems = 400;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   cycles;
	int   idle_pct;
	int   stall_pct;

	egcd_if #(.W($bits(in_t)))  in_bus();
	egcd_if #(.W($bits(out_t))) out_bus();

	extended_gcd_bezout DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_bus.sink),
		.out_ch(out_bus.source)
	);

	egcd_scoreboard checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.in_mon(in_bus),
		.out_mon(out_bus),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		in_bus.valid = 1'b0;
		in_bus.data = '0;
		out_bus.ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		cycles = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n)
			out_bus.ready <= ($urandom_range(99) >= stall_pct);

	// ready is sampled at the falling edge, where it holds its value for the next rising edge
	task automatic push_operands(input logic [OpW-1:0] a, input logic [OpW-1:0] b);
		logic took;
		while ($urandom_range(99) < idle_pct) begin
			in_bus.valid <= 1'b0;
			@(posedge clk);
		end
		in_bus.valid <= 1'b1;
		in_bus.data <= in_t'{first_value: a, second_value: b};
		do begin
			@(negedge clk);
			took = in_bus.ready;
			@(posedge clk);
		end while (!took);
	endtask

	function automatic logic [OpW-1:0] rand_operand();
		case ($urandom_range(5))
			0: return $urandom_range(255);
			1: return $urandom_range(65535);
			2: return $urandom_range(3) == 0 ? '0 : $urandom_range(15);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [OpW-1:0] a, b, f;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_operands(32'd0, 32'd0);
		push_operands(32'd12345, 32'd0);
		push_operands(32'd0, 32'd678);
		push_operands(32'd99, 32'd99);
		push_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_operands(32'hFFFF_FFFF, 32'd0);
		push_operands(32'd0, 32'hFFFF_FFFF);
		push_operands(32'hFFFF_FFFF, 32'd1);
		push_operands(32'd1, 32'hFFFF_FFFF);
		push_operands(32'hFFFF_FFFF, 32'hFFFF_FFFE);
		// consecutive Fibonacci numbers: longest chain
		push_operands(32'd2971215073, 32'd1836311903);
		push_operands(32'd1836311903, 32'd2971215073);
		push_operands(32'h8000_0000, 32'h7FFF_FFFF);
		push_operands(32'd240, 32'd46);
		push_operands(32'd46, 32'd240);
		push_operands(32'd1, 32'd1);
		push_operands(32'h8000_0000, 32'h4000_0000);

		for (int i = 0; i < RandomItems; i++) begin
			case (i / (RandomItems / 4))
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 68; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 68; end
				default: begin idle_pct = 8; stall_pct = 8; end
			endcase
			if (i % 25 < 3) begin
				idle_pct = 0;
				stall_pct = 0;
			end
			a = rand_operand();
			b = rand_operand();
			if ($urandom_range(3) == 0) begin
				// shared factor so the gcd is non-trivial
				f = $urandom_range(1, 5000);
				a = (a % 800000) * f;
				b = (b % 800000) * f;
			end
			push_operands(a, b);
		end
		in_bus.valid <= 1'b0;
		stall_pct = 0;

		while (outstanding != 0 || in_bus.valid)
			@(posedge clk);
		repeat (2000) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
